// ===== rtl/csvt_pkg.sv =====
`timescale 1ns / 1ps
package csvt_pkg;

  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_NUL = 8'h00;

  localparam logic [7:0] SEP_RESET   = 8'h2C;
  localparam logic [7:0] QUOTE_RESET = 8'h22;

  localparam logic REG_SEPARATOR = 1'b0;
  localparam logic REG_QUOTE     = 1'b1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_end;
    logic       is_sep;
    logic       is_lf;
    logic       is_cr;
    logic       is_quote;
  } cls_t;

endpackage

// ===== rtl/csvt_if.sv =====
`timescale 1ns / 1ps
interface csvt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_data;

  modport source (output valid, data_byte, end_of_data, input ready);
  modport sink (input valid, data_byte, end_of_data, output ready);
endinterface

interface csvt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       field_end;
  logic       record_end;

  modport source (output valid, out_byte, byte_valid, field_end, record_end, input ready);
  modport sink (input valid, out_byte, byte_valid, field_end, record_end, output ready);
endinterface

// ===== rtl/csvt_front.sv =====
`timescale 1ns / 1ps
module csvt_front (
  csvt_in_if.sink       in_stream,
  input  logic [7:0]    separator_char,
  input  logic [7:0]    quote_char,
  output logic          push_valid,
  input  logic          push_ready,
  output csvt_pkg::cls_t push_item
);
  import csvt_pkg::*;

  assign in_stream.ready = push_ready;
  assign push_valid      = in_stream.valid;

  // zero byte always means end, whatever the registers hold
  always_comb begin
    push_item.data_byte = in_stream.data_byte;
    push_item.is_end    = in_stream.end_of_data || (in_stream.data_byte == CH_NUL);
    push_item.is_sep    = (in_stream.data_byte == separator_char);
    push_item.is_lf     = (in_stream.data_byte == CH_LF);
    push_item.is_cr     = (in_stream.data_byte == CH_CR);
    push_item.is_quote  = (in_stream.data_byte == quote_char);
  end

endmodule

// ===== rtl/csvt_queue.sv =====
`timescale 1ns / 1ps
module csvt_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  csvt_pkg::cls_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output csvt_pkg::cls_t pop_item
);
  import csvt_pkg::*;

  cls_t              entry [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = entry[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count missed a push");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == QCNT_W'(QUEUE_DEPTH)) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers out of step with count");

endmodule

// ===== rtl/csvt_back.sv =====
`timescale 1ns / 1ps
module csvt_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  csvt_pkg::cls_t pop_item,
  csvt_out_if.source     out_stream
);
  import csvt_pkg::*;

  localparam logic [2:0] PH_REC_START  = 3'd0;
  localparam logic [2:0] PH_FLD_START  = 3'd1;
  localparam logic [2:0] PH_PLAIN      = 3'd2;
  localparam logic [2:0] PH_QUOTED     = 3'd3;
  localparam logic [2:0] PH_QUOTE_SEEN = 3'd4;
  localparam logic [2:0] PH_SKIP       = 3'd5;
  localparam logic [2:0] PH_AFTER_CR   = 3'd6;

  logic [2:0] phase;
  logic [2:0] phase_next;
  logic [2:0] ph;
  logic       pop;

  logic       out_valid;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       field_end;
  logic       record_end;

  logic       res_valid;
  logic [7:0] res_byte;
  logic       res_bv;
  logic       res_fe;
  logic       res_re;

  logic       d_hit;
  logic [2:0] d_phase;
  logic       d_rec;
  logic       lf_drop;

  assign pop_ready = !out_valid || out_stream.ready;
  assign pop       = pop_valid && pop_ready;

  assign out_stream.valid      = out_valid;
  assign out_stream.out_byte   = out_byte;
  assign out_stream.byte_valid = byte_valid;
  assign out_stream.field_end  = field_end;
  assign out_stream.record_end = record_end;

  // separator wins over LF and CR
  always_comb begin
    d_hit   = pop_item.is_sep || pop_item.is_lf || pop_item.is_cr;
    d_rec   = !pop_item.is_sep;
    d_phase = pop_item.is_sep ? PH_FLD_START :
              (pop_item.is_lf ? PH_REC_START : PH_AFTER_CR);
  end

  always_comb begin
    ph         = phase;
    phase_next = phase;
    res_valid  = 1'b0;
    res_byte   = 8'h00;
    res_bv     = 1'b0;
    res_fe     = 1'b0;
    res_re     = 1'b0;
    lf_drop    = 1'b0;

    if (ph == PH_AFTER_CR) begin
      if (!pop_item.is_end && pop_item.is_lf) begin
        phase_next = PH_REC_START;
        lf_drop    = 1'b1;
      end else begin
        ph = PH_REC_START;
      end
    end
    if (ph > PH_AFTER_CR) begin
      ph = PH_REC_START;
    end

    if (!lf_drop) begin
      unique case (ph)
        PH_REC_START, PH_FLD_START: begin
          if (pop_item.is_end) begin
            phase_next = PH_REC_START;
            res_valid  = (ph == PH_FLD_START);
            res_fe     = (ph == PH_FLD_START);
            res_re     = (ph == PH_FLD_START);
          end else if (pop_item.is_quote) begin
            phase_next = PH_QUOTED;
          end else if (d_hit) begin
            phase_next = d_phase;
            res_valid  = 1'b1;
            res_fe     = 1'b1;
            res_re     = d_rec;
          end else begin
            phase_next = PH_PLAIN;
            res_valid  = 1'b1;
            res_bv     = 1'b1;
            res_byte   = pop_item.data_byte;
          end
        end
        PH_PLAIN: begin
          if (pop_item.is_end) begin
            phase_next = PH_REC_START;
            res_valid  = 1'b1;
            res_fe     = 1'b1;
            res_re     = 1'b1;
          end else if (d_hit) begin
            phase_next = d_phase;
            res_valid  = 1'b1;
            res_fe     = 1'b1;
            res_re     = d_rec;
          end else begin
            res_valid  = 1'b1;
            res_bv     = 1'b1;
            res_byte   = pop_item.data_byte;
          end
        end
        PH_QUOTED: begin
          if (pop_item.is_end) begin
            phase_next = PH_REC_START;
            res_valid  = 1'b1;
            res_fe     = 1'b1;
            res_re     = 1'b1;
          end else if (pop_item.is_quote) begin
            phase_next = PH_QUOTE_SEEN;
          end else begin
            res_valid  = 1'b1;
            res_bv     = 1'b1;
            res_byte   = pop_item.data_byte;
          end
        end
        PH_QUOTE_SEEN: begin
          if (pop_item.is_end) begin
            phase_next = PH_REC_START;
            res_valid  = 1'b1;
            res_fe     = 1'b1;
            res_re     = 1'b1;
          end else if (pop_item.is_quote) begin
            // doubled quote
            phase_next = PH_QUOTED;
            res_valid  = 1'b1;
            res_bv     = 1'b1;
            res_byte   = pop_item.data_byte;
          end else if (d_hit) begin
            phase_next = d_phase;
            res_valid  = 1'b1;
            res_fe     = 1'b1;
            res_re     = d_rec;
          end else begin
            phase_next = PH_SKIP;
          end
        end
        default: begin
          // skipping junk after a closing quote
          if (pop_item.is_end) begin
            phase_next = PH_REC_START;
            res_valid  = 1'b1;
            res_fe     = 1'b1;
            res_re     = 1'b1;
          end else if (d_hit) begin
            phase_next = d_phase;
            res_valid  = 1'b1;
            res_fe     = 1'b1;
            res_re     = d_rec;
          end else begin
            phase_next = PH_SKIP;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_REC_START;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        phase     <= phase_next;
        out_valid <= res_valid;
      end else if (out_stream.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && res_valid) begin
      out_byte   <= res_byte;
      byte_valid <= res_bv;
      field_end  <= res_fe;
      record_end <= res_re;
    end
  end

  a_kind_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (byte_valid != field_end))
    else $error("result is neither a byte nor a field end, or both");

  a_rec_needs_field: assert property (@(posedge clk) disable iff (rst)
    (out_valid && record_end) |-> field_end)
    else $error("record end without field end");

  a_no_pop_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stream.ready) |-> !pop)
    else $error("item consumed while a result is stalled");

  a_reset_phase: assert property (@(posedge clk)
    rst |=> (phase == PH_REC_START && !out_valid))
    else $error("reset did not return to start of record");

endmodule

// ===== rtl/csv_field_tokenizer_top.sv =====
`timescale 1ns / 1ps
// CSV field tokenizer. Takes one CSV byte per transfer and returns field
// content bytes, field ends and record ends, with quoted fields unwrapped and
// doubled quotes collapsed. A new byte is accepted every cycle while results
// are taken; the sustained rate of one byte per cycle is set by the phase
// update in the back end. A result passes through classification into a
// two-entry queue, then the phase update into the output register. Bytes
// that produce no result (an opening quote, an LF after CR, data after a
// closing quote) still pass through the queue and the phase update.
// Separator and quote characters sit at APB addresses 0x0 and 0x4 and should
// only be changed while the block is idle. No initialisation time after reset.
module csv_field_tokenizer_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  csvt_in_if.sink      in_stream,
  csvt_out_if.source   out_stream
);
  import csvt_pkg::*;

  logic [7:0] separator_char;
  logic [7:0] quote_char;
  logic       wr_en;
  logic       reg_idx;

  logic       push_valid;
  logic       push_ready;
  cls_t       push_item;
  logic       pop_valid;
  logic       pop_ready;
  cls_t       pop_item;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      separator_char <= SEP_RESET;
      quote_char     <= QUOTE_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SEPARATOR: separator_char <= pwdata[7:0];
        REG_QUOTE:     quote_char     <= pwdata[7:0];
        default:       separator_char <= separator_char;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SEPARATOR: prdata = {24'h000000, separator_char};
      REG_QUOTE:     prdata = {24'h000000, quote_char};
      default:       prdata = '0;
    endcase
  end

  csvt_front u_front (
    .in_stream      (in_stream),
    .separator_char (separator_char),
    .quote_char     (quote_char),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_item      (push_item)
  );

  csvt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  csvt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item),
    .out_stream (out_stream)
  );

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import csvt_pkg::*;

  typedef enum logic [2:0] {
    ST_RECORD, ST_FIELD, ST_BARE, ST_QUOTED, ST_CLOSE_Q, ST_DISCARD, ST_AFTER_CR
  } tok_phase_e;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       field_end;
    logic       record_end;
  } tok_t;

  typedef enum logic [1:0] {ROW_PRED, ROW_NONE, ROW_GIVEN} row_kind_e;

  typedef struct packed {
    logic [7:0] b;
    logic       eod;
    row_kind_e  kind;
    tok_t       want;
  } row_t;

  localparam tok_t END_FLD = '{8'h00, 1'b0, 1'b1, 1'b0};
  localparam tok_t END_REC = '{8'h00, 1'b0, 1'b1, 1'b1};
  localparam tok_t NO_TOK  = '0;

  localparam logic [2:0] ADDR_SEP   = {REG_SEPARATOR, 2'b00};
  localparam logic [2:0] ADDR_QUOTE = {REG_QUOTE, 2'b00};

  localparam int DRAIN_CYCLES = 6;
  localparam int LONG_HOLD    = 300;
  localparam int PHASE_ITEMS  = 75;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  csvt_in_if  in_if ();
  csvt_out_if out_if ();

  csv_field_tokenizer_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_stream  (in_if),
    .out_stream (out_if)
  );

  always #2 clk = ~clk;

  tok_phase_e tok_phase;
  logic [7:0] cfg_sep;
  logic [7:0] cfg_quote;
  tok_t       tok_q[$];
  row_t       dir_tab [24];
  int         n_items;
  int         n_checked;
  int         errors;
  int         src_calm;
  bit         long_hold;

  function automatic bit tokenize(input logic [7:0] b, input logic eod, output tok_t r);
    logic       fin;
    tok_phase_e ph;
    r   = NO_TOK;
    fin = eod || (b == CH_NUL);
    ph  = tok_phase;
    if (ph == ST_AFTER_CR) begin
      if (!fin && b == CH_LF) begin
        tok_phase = ST_RECORD;
        return 1'b0;
      end
      ph = ST_RECORD;
    end
    if (fin) begin
      tok_phase = ST_RECORD;
      if (ph == ST_RECORD) return 1'b0;
      r = END_REC;
      return 1'b1;
    end
    if ((ph == ST_RECORD || ph == ST_FIELD) && b == cfg_quote) begin
      tok_phase = ST_QUOTED;
      return 1'b0;
    end
    if (ph == ST_QUOTED) begin
      if (b == cfg_quote) begin
        tok_phase = ST_CLOSE_Q;
        return 1'b0;
      end
      r = '{b, 1'b1, 1'b0, 1'b0};
      return 1'b1;
    end
    if (ph == ST_CLOSE_Q && b == cfg_quote) begin
      tok_phase = ST_QUOTED;
      r = '{b, 1'b1, 1'b0, 1'b0};
      return 1'b1;
    end
    // separator wins over LF and CR
    if (b == cfg_sep) begin
      tok_phase = ST_FIELD;
      r = END_FLD;
      return 1'b1;
    end
    if (b == CH_LF) begin
      tok_phase = ST_RECORD;
      r = END_REC;
      return 1'b1;
    end
    if (b == CH_CR) begin
      tok_phase = ST_AFTER_CR;
      r = END_REC;
      return 1'b1;
    end
    if (ph == ST_CLOSE_Q || ph == ST_DISCARD) begin
      tok_phase = ST_DISCARD;
      return 1'b0;
    end
    tok_phase = ST_BARE;
    r = '{b, 1'b1, 1'b0, 1'b0};
    return 1'b1;
  endfunction

  function automatic int pick_gap(input int calm);
    int r;
    r = $urandom_range(0, 99);
    if (r < calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] text_byte();
    if ($urandom_range(0, 9) < 7) return 8'h61 + 8'($urandom_range(0, 25));
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic void cmp_field(input string name, input logic [7:0] want,
                                    input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  task automatic send_item(input logic [7:0] b, input logic eod, input row_kind_e kind,
                           input tok_t want);
    int   gap;
    tok_t r;
    bit   has;
    gap = pick_gap(src_calm);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.data_byte   <= b;
    in_if.end_of_data <= eod;
    do @(posedge clk); while (!in_if.ready);
    n_items++;
    has = tokenize(b, eod, r);
    case (kind)
      ROW_PRED:  if (has) tok_q.push_back(r);
      ROW_GIVEN: tok_q.push_back(want);
      default: ;
    endcase
  endtask

  task automatic put(input logic [7:0] b, input logic eod);
    send_item(b, eod, ROW_PRED, NO_TOK);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (tok_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reg_access(input logic [2:0] a, input logic [7:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= {24'h0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[7:0] !== v) begin
      $display("%0t: readback at %0h, expected %0h, got %0h", $time, a, v, prdata[7:0]);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_chars(input logic [7:0] sep, input logic [7:0] quo);
    drain();
    reg_access(ADDR_SEP, sep);
    reg_access(ADDR_QUOTE, quo);
    cfg_sep   = sep;
    cfg_quote = quo;
  endtask

  task automatic send_field();
    int len;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 5);
    if ($urandom_range(0, 2) == 0) begin
      put(cfg_quote, 1'b0);
      repeat (len) begin
        if ($urandom_range(0, 6) == 0) begin
          put(cfg_quote, 1'b0);
          put(cfg_quote, 1'b0);
        end else begin
          put(text_byte(), 1'b0);
        end
      end
      put(cfg_quote, 1'b0);
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 3)) put(text_byte(), 1'b0);
    end else begin
      repeat (len) put(text_byte(), 1'b0);
    end
  endtask

  task automatic send_record();
    int nf;
    nf = $urandom_range(1, 4);
    for (int i = 0; i < nf; i++) begin
      if (i != 0) put(cfg_sep, 1'b0);
      send_field();
    end
    case ($urandom_range(0, 4))
      0: put(CH_LF, 1'b0);
      1: put(CH_CR, 1'b0);
      2: begin
        put(CH_CR, 1'b0);
        put(CH_LF, 1'b0);
      end
      3: put(8'($urandom), 1'b1);
      default: put(CH_NUL, 1'b0);
    endcase
  endtask

  task automatic run_phase(input int n);
    int start;
    start = n_items;
    while (n_items - start < n) begin
      if ($urandom_range(0, 9) < 8) begin
        send_record();
      end else begin
        repeat ($urandom_range(1, 8))
          put(8'($urandom_range(0, 255)), ($urandom_range(0, 15) == 0));
      end
    end
  endtask

  // result sink: random stalls, one long hold-off on request
  initial begin
    int n_off;
    int n_on;
    out_if.ready <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      n_off = pick_gap(40);
      if (long_hold) begin
        long_hold = 1'b0;
        n_off += LONG_HOLD;
      end
      if (n_off > 0) begin
        out_if.ready <= 1'b0;
        repeat (n_off) @(posedge clk);
      end
      n_on = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
      out_if.ready <= 1'b1;
      repeat (n_on) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    tok_t want;
    if (!rst && out_if.valid && out_if.ready) begin
      n_checked++;
      if (tok_q.size() == 0) begin
        $display("%0t: transfer with none expected, got byte %0h bv %b fe %b re %b",
                 $time, out_if.out_byte, out_if.byte_valid, out_if.field_end,
                 out_if.record_end);
        errors++;
      end else begin
        want = tok_q.pop_front();
        cmp_field("out_byte", want.out_byte, out_if.out_byte);
        cmp_field("byte_valid", 8'(want.byte_valid), 8'(out_if.byte_valid));
        cmp_field("field_end", 8'(want.field_end), 8'(out_if.field_end));
        cmp_field("record_end", 8'(want.record_end), 8'(out_if.record_end));
      end
    end
  end

  initial begin
    #3_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst               <= 1'b1;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    in_if.valid       <= 1'b0;
    in_if.data_byte   <= '0;
    in_if.end_of_data <= 1'b0;
    tok_phase = ST_RECORD;
    cfg_sep   = SEP_RESET;
    cfg_quote = QUOTE_RESET;
    src_calm  = 50;
    long_hold = 1'b0;
    n_items   = 0;
    n_checked = 0;
    errors    = 0;
    dir_tab = '{
      '{8'h00, 1'b1, ROW_NONE,  NO_TOK},
      '{CH_NUL, 1'b0, ROW_NONE, NO_TOK},
      '{8'h61, 1'b0, ROW_PRED,  NO_TOK},
      '{8'h2C, 1'b0, ROW_GIVEN, END_FLD},
      '{8'hFF, 1'b1, ROW_GIVEN, END_REC},
      '{8'h22, 1'b0, ROW_NONE,  NO_TOK},
      '{8'h78, 1'b0, ROW_PRED,  NO_TOK},
      '{8'h22, 1'b0, ROW_NONE,  NO_TOK},
      '{8'h22, 1'b0, ROW_PRED,  NO_TOK},
      '{8'h22, 1'b0, ROW_NONE,  NO_TOK},
      '{8'h79, 1'b0, ROW_NONE,  NO_TOK},
      '{8'h2C, 1'b0, ROW_GIVEN, END_FLD},
      '{8'h62, 1'b0, ROW_PRED,  NO_TOK},
      '{8'h22, 1'b0, ROW_PRED,  NO_TOK},
      '{CH_CR, 1'b0, ROW_GIVEN, END_REC},
      '{CH_LF, 1'b0, ROW_NONE,  NO_TOK},
      '{CH_LF, 1'b0, ROW_GIVEN, END_REC},
      '{CH_CR, 1'b0, ROW_GIVEN, END_REC},
      '{CH_CR, 1'b0, ROW_GIVEN, END_REC},
      '{8'hFF, 1'b0, ROW_PRED,  NO_TOK},
      '{CH_NUL, 1'b0, ROW_GIVEN, END_REC},
      '{8'h22, 1'b0, ROW_NONE,  NO_TOK},
      '{8'h01, 1'b0, ROW_PRED,  NO_TOK},
      '{8'h00, 1'b1, ROW_GIVEN, END_REC}
    };
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i])
      send_item(dir_tab[i].b, dir_tab[i].eod, dir_tab[i].kind, dir_tab[i].want);

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_chars(SEP_RESET, QUOTE_RESET);
        1: set_chars(8'h00, 8'hFF);
        2: set_chars(8'hFF, 8'h00);
        3: set_chars(CH_LF, QUOTE_RESET);
        4: set_chars(CH_CR, CH_LF);
        5: set_chars(8'h3B, 8'h3B);
        6: set_chars(8'h09, 8'h27);
        default: set_chars(8'($urandom), 8'($urandom));
      endcase
      case ($urandom_range(0, 2))
        0: src_calm = 100;
        1: src_calm = 70;
        default: src_calm = 40;
      endcase
      if (p == 3) begin
        src_calm  = 100;
        long_hold = 1'b1;
        // start sending once the sink has begun its hold-off
        wait (!long_hold);
      end
      run_phase(PHASE_ITEMS);
      if (p == 5) begin
        in_if.valid <= 1'b0;
        while (tok_q.size() != 0) @(posedge clk);
      end
      run_phase(PHASE_ITEMS);
    end
    drain();

    $display("Tokenized %0d bytes under 8 separator/quote settings, %0d results compared",
             n_items, n_checked);
    $display("Mismatches: %0d", errors);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
